/* src/pre_pkg.sv */
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants for the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

   localparam int HOLD_DEPTH = 16;
   localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
   localparam int COUNT_W    = $clog2(HOLD_DEPTH + 1);
   localparam int BYTE_W     = 8;
   localparam int CSR_W      = 5;

   localparam logic [BYTE_W-1:0]  NEWLINE_BYTE   = 8'h0A;
   localparam logic [BYTE_W-1:0]  PRINTABLE_LO   = 8'h20;
   localparam logic [BYTE_W-1:0]  PRINTABLE_HI   = 8'h7E;
   localparam logic [CSR_W-1:0]   DEFAULT_MIN    = 5'd2;
   localparam logic [COUNT_W-1:0] HOLD_DEPTH_CNT = COUNT_W'(HOLD_DEPTH);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } pre_state_type;

   typedef struct packed {
      logic                  load;
      logic                  shift;
      logic [HOLD_IDX_W-1:0] wr_index;
   } pre_chain_ctrl_type;

endpackage

/* src/printable_run_extractor.sv */
// ----------------------------------------------------------------------------
// printable_run_extractor
// Passes runs of printable ASCII of at least the programmed length,
// each closed by a newline.
// ----------------------------------------------------------------------------
// A request yields no response or a single one (a byte inside an open run,
// or the newline that closes it), except that a printable byte that brings
// the held run up to the minimum starts a burst: the held bytes, this one
// included, leave the 16-cell hold chain one per cycle while the response
// is not stalled. A burst holds at most 16 bytes, and no request is taken
// while the chain drains. A stalled response also holds off new requests.
module printable_run_extractor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pre_pkg::BYTE_W-1:0]     req_byte_in,
   input  logic                           req_stream_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pre_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_last_of_burst,
   input  logic                           csr_wr_en,
   input  logic [pre_pkg::CSR_W-1:0]      csr_wr_data
);

   pre_pkg::pre_state_type         state_ff, state_in;
   logic [pre_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                           in_run_ff, in_run_in;
   logic [pre_pkg::CSR_W-1:0]      min_len_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pre_pkg::BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                           rsp_last_ff, rsp_last_in;

   pre_pkg::pre_chain_ctrl_type    chain_ctrl;
   logic [pre_pkg::BYTE_W-1:0]     head_byte;
   logic [pre_pkg::COUNT_W-1:0]    eff_min;
   logic [pre_pkg::COUNT_W-1:0]    count_inc;
   logic                           out_free;
   logic                           accept;
   logic                           printable;

   // zero acts as one, above the chain depth acts as the depth
   always_comb begin
      if (min_len_ff == '0) begin
         eff_min = pre_pkg::COUNT_W'(1);
      end else if (pre_pkg::COUNT_W'(min_len_ff) > pre_pkg::HOLD_DEPTH_CNT) begin
         eff_min = pre_pkg::HOLD_DEPTH_CNT;
      end else begin
         eff_min = pre_pkg::COUNT_W'(min_len_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pre_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign printable = (req_byte_in >= pre_pkg::PRINTABLE_LO) &&
                      (req_byte_in <= pre_pkg::PRINTABLE_HI);
   assign count_inc = count_ff + pre_pkg::COUNT_W'(1);

   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      in_run_in           = in_run_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_byte_in         = rsp_byte_ff;
      rsp_last_in         = rsp_last_ff;
      chain_ctrl.load     = 1'b0;
      chain_ctrl.shift    = 1'b0;
      chain_ctrl.wr_index = count_ff[pre_pkg::HOLD_IDX_W-1:0];
      case (state_ff)
         pre_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_stream_end || !printable) begin
                  count_in  = '0;
                  in_run_in = 1'b0;
                  if (in_run_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = pre_pkg::NEWLINE_BYTE;
                     rsp_last_in  = 1'b1;
                  end
               end else if (in_run_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_byte_in;
                  rsp_last_in  = 1'b1;
               end else begin
                  chain_ctrl.load = 1'b1;
                  count_in        = count_inc;
                  if (count_inc >= eff_min) begin
                     state_in = pre_pkg::ST_DRAIN;
                  end
               end
            end
         end
         pre_pkg::ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = head_byte;
               rsp_last_in      = (count_ff == pre_pkg::COUNT_W'(1));
               chain_ctrl.shift = 1'b1;
               count_in         = count_ff - pre_pkg::COUNT_W'(1);
               if (count_ff == pre_pkg::COUNT_W'(1)) begin
                  state_in  = pre_pkg::ST_IDLE;
                  in_run_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = pre_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pre_pkg::ST_IDLE;
         count_ff     <= '0;
         in_run_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_len_ff   <= pre_pkg::DEFAULT_MIN;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         in_run_ff    <= in_run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   pre_hold_chain u_hold_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .load_byte (req_byte_in),
      .head_byte (head_byte)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_burst = rsp_last_ff;

endmodule

/* src/pre_cell.sv */
// ----------------------------------------------------------------------------
// pre_cell
// One byte slot of the hold chain: loads a new byte or takes its neighbor's.
// ----------------------------------------------------------------------------
module pre_cell (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        shift,
   input  logic [pre_pkg::BYTE_W-1:0]  load_byte,
   input  logic [pre_pkg::BYTE_W-1:0]  next_byte,
   output logic [pre_pkg::BYTE_W-1:0]  cell_byte
);

   logic [pre_pkg::BYTE_W-1:0] byte_ff;
   logic [pre_pkg::BYTE_W-1:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (load) begin
         byte_in = load_byte;
      end else if (shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

/* src/pre_hold_chain.sv */
// ----------------------------------------------------------------------------
// pre_hold_chain
// Row of hold cells; appends at the fill index, drains from cell 0.
// ----------------------------------------------------------------------------
module pre_hold_chain (
   input  logic                          clock,
   input  pre_pkg::pre_chain_ctrl_type   ctrl,
   input  logic [pre_pkg::BYTE_W-1:0]    load_byte,
   output logic [pre_pkg::BYTE_W-1:0]    head_byte
);

   logic [pre_pkg::BYTE_W-1:0] cell_data [pre_pkg::HOLD_DEPTH];

   for (genvar i = 0; i < pre_pkg::HOLD_DEPTH; i++) begin : g_cell
      logic                       cell_load;
      logic [pre_pkg::BYTE_W-1:0] next_byte;

      assign cell_load = ctrl.load && (ctrl.wr_index == pre_pkg::HOLD_IDX_W'(i));

      if (i == pre_pkg::HOLD_DEPTH - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = cell_data[i+1];
      end

      pre_cell u_cell (
         .clock     (clock),
         .load      (cell_load),
         .shift     (ctrl.shift),
         .load_byte (load_byte),
         .next_byte (next_byte),
         .cell_byte (cell_data[i])
      );
   end

   assign head_byte = cell_data[0];

endmodule

/* src/printable_run_extractor_checker.sv */
// ----------------------------------------------------------------------------
// printable_run_extractor_checker
// Port-level checks for the printable run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module printable_run_extractor_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pre_pkg::BYTE_W-1:0]     rsp_out_byte,
   input logic                           rsp_last_of_burst
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_last_of_burst))
      else $error("response changed while stalled");

   a_rsp_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_byte == pre_pkg::NEWLINE_BYTE) ||
                    ((rsp_out_byte >= pre_pkg::PRINTABLE_LO) &&
                     (rsp_out_byte <= pre_pkg::PRINTABLE_HI)))
      else $error("response byte neither printable nor newline");

   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind printable_run_extractor printable_run_extractor_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_last_of_burst (rsp_last_of_burst)
);
